@@ src/timestamp_keyed_password_scrambler_defines.svh @@
// Assertion macros for the timestamp keyed password scrambler.
`ifndef TIMESTAMP_KEYED_PASSWORD_SCRAMBLER_DEFINES_SVH
`define TIMESTAMP_KEYED_PASSWORD_SCRAMBLER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TKPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkps assertion failed");
// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TKPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkps assertion failed");
`else
`define TKPS_ASSERT_NOW(label, ante, cons)
`define TKPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/tkps_pkg.sv @@
// Shared types and constants of the timestamp keyed password scrambler.
package tkps_pkg;

  localparam int DIGITS     = 10;
  localparam int BCD_DIGITS = 11;
  localparam int TS_W       = 34;
  localparam int CHAR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int MIX_W      = 32;
  localparam int CONST_W    = 16;
  localparam int CONV_STEPS = TS_W;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int ROUNDS     = DIGITS / 2;
  localparam int ROUND_W    = $clog2(ROUNDS);

  localparam logic [CONST_W-1:0] MUL_A = 16'h4E35;
  localparam logic [CONST_W-1:0] MUL_B = 16'h015A;
  // Upper three bits of ASCII '0'..'9'
  localparam logic [2:0] ASCII_DIGIT_HI = 3'b011;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LOAD,
    S_CUR,
    S_PREV,
    S_LINK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start_conv;
    logic conv_step;
    logic digits_load;
    logic start_char;
    logic op_cur;
    logic op_prev;
    logic op_link;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic round_last;
    logic out_full;
  } stat_t;

endpackage

@@ src/tkps_ctrl.sv @@
// Controller state machine of the timestamp keyed password scrambler.
module tkps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mode,
  input  logic           out_ready,
  input  tkps_pkg::stat_t stat,
  output logic           in_ready,
  output tkps_pkg::cmd_t cmd
);
  import tkps_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.start_char = 1'b1;
            state_nxt      = S_CUR;
          end else begin
            cmd.start_conv = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.digits_load = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_CUR: begin
        cmd.op_cur = 1'b1;
        state_nxt  = S_PREV;
      end
      S_PREV: begin
        cmd.op_prev = 1'b1;
        state_nxt   = S_LINK;
      end
      S_LINK: begin
        cmd.op_link = 1'b1;
        state_nxt   = stat.round_last ? S_FIN : S_CUR;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!stat.out_full || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/tkps_dp.sv @@
// Datapath of the timestamp keyed password scrambler: digit conversion, store and mixing.
module tkps_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tkps_pkg::cmd_t                     cmd,
  input  logic [tkps_pkg::TS_W-1:0]          in_timestamp,
  input  logic [tkps_pkg::CHAR_W-1:0]        in_plain_char,
  input  logic                               out_ready,
  output tkps_pkg::stat_t                    stat,
  output logic                               out_valid,
  output logic [tkps_pkg::BYTE_W-1:0]        out_cipher_byte
);
  import tkps_pkg::*;

  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int SEL_W = 4 * DIGITS;

  logic [TS_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, bcd_adj;
  logic [SEL_W-1:0]   bcd_sel;
  logic [CHAR_W-1:0]  dig_r [DIGITS];
  logic [CHAR_W-1:0]  dig_nxt [DIGITS];
  logic [CHAR_W-1:0]  ch_r;
  logic [MIX_W-1:0]   cur_r, prev_r, link_r, acc_r, s_r;
  logic [MIX_W-1:0]   pair, link_nxt;
  logic [ROUND_W-1:0] round_r;
  logic [MIX_W-1:0]   mul_a;
  logic [CONST_W-1:0] mul_b;
  logic [MIX_W+CONST_W-1:0] prod_full;
  logic [MIX_W-1:0]   prod;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;

  function automatic logic [3:0] dab_adjust(input logic [3:0] nib);
    logic [3:0] res;
    res = (nib >= 4'd5) ? nib + 4'd3 : nib;
    return res;
  endfunction

  // shift-and-add-3 conversion, one binary bit per step
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dab_adjust(bcd_r[4*i +: 4]);
    end
    bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[TS_W-1]};
    bin_nxt = {bin_r[TS_W-2:0], 1'b0};
  end

  // eleven digits: keep the leading ten
  assign bcd_sel = (bcd_r[BCD_W-1 -: 4] != 4'd0) ? bcd_r[BCD_W-1:4] : bcd_r[SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start_conv) begin
      bin_r <= in_timestamp;
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = s_r;
    mul_b = MUL_A;
    if (cmd.op_cur) begin
      mul_a = cur_r + {{(MIX_W-ROUND_W){1'b0}}, round_r};
    end else if (cmd.op_prev) begin
      mul_b = MUL_B;
    end
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[MIX_W-1:0];
  assign pair      = {17'b0, dig_r[0], 1'b0, dig_r[1]};
  assign link_nxt  = prod + 32'd1;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      dig_nxt[k] = dig_r[k];
      if (cmd.digits_load) begin
        dig_nxt[k] = {ASCII_DIGIT_HI, bcd_sel[SEL_W-1-4*k -: 4]};
      end else if (cmd.op_link) begin
        dig_nxt[k] = dig_r[(k + 2) % DIGITS];
      end else if (cmd.finish) begin
        dig_nxt[k] = dig_r[k] ^ ch_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIGITS; k++) begin
        dig_r[k] <= '0;
      end
      cur_r  <= '0;
      prev_r <= '0;
    end else begin
      for (int k = 0; k < DIGITS; k++) begin
        dig_r[k] <= dig_nxt[k];
      end
      if (cmd.start_conv) begin
        cur_r  <= '0;
        prev_r <= '0;
      end else if (cmd.op_cur) begin
        cur_r <= prev_r + prod;
      end else if (cmd.op_prev) begin
        prev_r <= prod;
        cur_r  <= cur_r + prod;
      end
    end
  end

  // per-character working registers
  always_ff @(posedge clk) begin
    if (cmd.start_char) begin
      ch_r    <= in_plain_char;
      link_r  <= '0;
      acc_r   <= '0;
      round_r <= '0;
    end else begin
      if (cmd.op_cur) begin
        s_r <= link_r ^ pair;
      end
      if (cmd.op_link) begin
        link_r  <= link_nxt;
        acc_r   <= acc_r ^ cur_r ^ link_nxt;
        round_r <= round_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_byte_r <= {1'b0, ch_r} ^ acc_r[7:0] ^ acc_r[15:8];
    end
  end

  assign stat.round_last = (round_r == ROUND_W'(ROUNDS - 1));
  assign stat.out_full   = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

endmodule

@@ src/timestamp_keyed_password_scrambler.sv @@
// Top level of the timestamp keyed password scrambler.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_mode, in_timestamp,     | sink
//          | in_plain_char                                  |
//  out     | out_valid, out_ready, out_cipher_byte          | source
//
// A start item (mode 0) is worked in order: accept, 34 conversion steps through
// the shift-and-add-3 converter, then the digit store load. It gives no item.
// A character item is worked in order: accept, five rounds of three passes
// through the single shared 32x16 multiplier, then the finishing step to update the
// digits and fill the output register. One item is worked on at a time.
// rst_n is synchronous and active low; it clears the digits, both mixing
// accumulators, the state machine and out_valid.
// A stalled output holds the finishing step until out_ready; a new item is taken
// as soon as the block is back in idle, even while the previous result waits.
`include "timestamp_keyed_password_scrambler_defines.svh"

module timestamp_keyed_password_scrambler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [tkps_pkg::TS_W-1:0]          in_timestamp,
  input  logic [tkps_pkg::CHAR_W-1:0]        in_plain_char,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tkps_pkg::BYTE_W-1:0]        out_cipher_byte
);
  import tkps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequence the conversion and the mixing rounds
  tkps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // digit store, accumulators, multiplier and output register
  tkps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_timestamp    (in_timestamp),
    .in_plain_char   (in_plain_char),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_cipher_byte (out_cipher_byte)
  );

  // a character item keeps the block busy while its rounds run
  `TKPS_ASSERT_NEXT(a_char_busy, in_valid && in_ready && in_mode, !in_ready)
  // never overwrite a result that has not been taken
  `TKPS_ASSERT_NOW(a_fin_free, cmd.finish, !out_valid || out_ready)
  // a new result only comes from the finishing step
  `TKPS_ASSERT_NOW(a_out_src, $rose(out_valid), $past(cmd.finish))

endmodule
